// File: rtl/rflfr_pkg.sv
// Package with shared types and constants for the RF link frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package rflfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int EVENT_W = 3;
    localparam int CFG_ADDR_W = 2;

    localparam logic [2:0] LEN_MASK = 3'b111;
    localparam logic [2:0] LEN_EXTENDED = 3'd7;

    localparam logic [7:0] ACK_CODE_RESET    = 8'd6;
    localparam logic [7:0] NACK_CODE_RESET   = 8'd21;
    localparam logic [7:0] RETRY_LIMIT_RESET = 8'd3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ACK_CODE    = 2'd0,
        CFG_NACK_CODE   = 2'd1,
        CFG_RETRY_LIMIT = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_COMMAND = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_DATA    = 3'd3,
        PH_CHECK   = 3'd4
    } phase_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_PAYLOAD = 3'd0,
        EV_GOOD    = 3'd1,
        EV_BAD     = 3'd2,
        EV_ACKED   = 3'd3,
        EV_RESEND  = 3'd4,
        EV_DROPPED = 3'd5
    } event_t;

    typedef struct packed {
        logic [BYTE_W-1:0] ack_code;
        logic [BYTE_W-1:0] nack_code;
        logic [BYTE_W-1:0] retry_limit;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        event_t            event_res;
        logic [BYTE_W-1:0] value;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/rflfr_parser.sv
// Frame parser state machine that turns each accepted byte into at most one result.
`timescale 1ns / 1ps
`default_nettype none

module rflfr_parser
    import rflfr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              byte_accept,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire cfg_t              cfg,
    output result_t                result
);

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] remaining_reg, remaining_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic              ext_reg, ext_next;
    logic [BYTE_W-1:0] header_reg, header_next;
    logic [BYTE_W-1:0] retry_reg, retry_next;
    logic [BYTE_W-1:0] data_left;

    assign data_left = (remaining_reg != '0) ? remaining_reg - 1'b1 : remaining_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            remaining_reg <= '0;
            xor_reg       <= '0;
            ext_reg       <= 1'b0;
            header_reg    <= '0;
            retry_reg     <= '0;
        end else if (byte_accept) begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            xor_reg       <= xor_next;
            ext_reg       <= ext_next;
            header_reg    <= header_next;
            retry_reg     <= retry_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        xor_next       = xor_reg ^ rx_byte;
        ext_next       = ext_reg;
        header_next    = header_reg;
        retry_next     = retry_reg;
        case (phase_reg)
            PH_HEADER: begin
                xor_next = xor_reg;
                if (rx_byte == cfg.ack_code) begin
                    retry_next = '0;
                end else if (rx_byte == cfg.nack_code) begin
                    if (retry_reg >= cfg.retry_limit) begin
                        retry_next = BYTE_W'(1);
                    end else begin
                        retry_next = retry_reg + 1'b1;
                    end
                end else begin
                    header_next    = rx_byte;
                    xor_next       = rx_byte;
                    remaining_next = BYTE_W'(rx_byte[2:0] & LEN_MASK);
                    ext_next       = ((rx_byte[2:0] & LEN_MASK) == LEN_EXTENDED);
                    phase_next     = PH_COMMAND;
                end
            end
            PH_COMMAND: begin
                if (ext_reg) begin
                    remaining_next = rx_byte;
                    phase_next     = PH_EXTLEN;
                end else begin
                    phase_next = (remaining_reg == '0) ? PH_CHECK : PH_DATA;
                end
            end
            PH_EXTLEN: begin
                remaining_next = rx_byte;
                phase_next     = (rx_byte == '0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
                remaining_next = data_left;
                if (data_left == '0) begin
                    phase_next = PH_CHECK;
                end
            end
            default: begin
                phase_next     = PH_HEADER;
                xor_next       = '0;
                remaining_next = '0;
                ext_next       = 1'b0;
            end
        endcase
    end

    always_comb begin
        result.valid     = 1'b1;
        result.event_res = EV_PAYLOAD;
        result.value     = '0;
        result.last      = 1'b0;
        case (phase_reg)
            PH_HEADER: begin
                if (rx_byte == cfg.ack_code) begin
                    result.event_res = EV_ACKED;
                end else if (rx_byte == cfg.nack_code) begin
                    result.event_res = (retry_reg >= cfg.retry_limit) ? EV_DROPPED : EV_RESEND;
                end else begin
                    result.valid = 1'b0;
                end
            end
            PH_COMMAND: begin
                result.valid = !ext_reg;
                result.value = rx_byte;
                result.last  = (remaining_reg == '0);
            end
            PH_EXTLEN: begin
                result.value = remaining_reg;
                result.last  = (rx_byte == '0);
            end
            PH_DATA: begin
                result.value = rx_byte;
                result.last  = (data_left == '0);
            end
            default: begin
                result.event_res = ((xor_reg ^ rx_byte) == '0) ? EV_GOOD : EV_BAD;
                result.value     = header_reg;
            end
        endcase
    end

    a_ext_only_with_seven: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_EXTLEN) |-> ext_reg && (header_reg[2:0] == LEN_EXTENDED))
        else $error("Extended length phase reached without an extended header.");

    a_check_resets_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_accept && (phase_reg == PH_CHECK) |=> (phase_reg == PH_HEADER) && (xor_reg == '0))
        else $error("Frame state not cleared after the checksum byte.");

    a_header_sets_xor: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_COMMAND) |-> (xor_reg == header_reg))
        else $error("Running XOR does not start from the frame header.");

endmodule

`default_nettype wire

// File: rtl/rflfr_out_stage.sv
// Output register stage that holds one result while the downstream side stalls.
`timescale 1ns / 1ps
`default_nettype none

module rflfr_out_stage
    import rflfr_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire result_t            result,
    output logic                    ready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [BYTE_W-1:0]       m_tdata,
    output logic [EVENT_W-1:0]      m_tuser,
    output logic                    m_tlast
);

    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;
    event_t            event_reg;
    logic              last_reg;

    assign ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready) begin
            valid_reg <= load && result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready && load && result.valid) begin
            data_reg  <= result.value;
            event_reg <= result.event_res;
            last_reg  <= result.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = event_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// File: rtl/rf_link_frame_receiver_unit.sv
// Top level of the RF link frame receiver: configuration registers, parser and output stage.
//
// The slave stream carries one received link byte per transfer in s_tdata. Each byte
// produces zero or one result on the master stream: a payload byte (command or data,
// with m_tlast on the final one), a frame good or bad report carrying the header at
// the checksum byte, or an acknowledge, resend or drop report for a partner reply.
// The header byte produces nothing, and neither does the command byte of an
// extended-length frame; that command byte comes out with the length byte.
// A result appears on the master side in the cycle after its input transfer. The block
// takes one byte per cycle unless the master side stalls; the single output register lets
// a new byte enter while the previous result is taken.
// When the master side stalls, the output register holds its result and s_tready
// drops until that result is taken.
// The configuration port writes the acknowledge code, reject code and retry limit
// by index; write it only while no transfer is in flight.
// A synchronous active-low reset returns the parser to waiting for a header, clears
// the retry count and output valid, and restores the default codes (6, 21, limit 3).
`timescale 1ns / 1ps
`default_nettype none

module rf_link_frame_receiver_unit
    import rflfr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [BYTE_W-1:0]          m_tdata,   // [7:0] value
    output logic [EVENT_W-1:0]         m_tuser,   // [2:0] event_res
    output logic                       m_tlast,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [BYTE_W-1:0]     cfg_wdata
);

    cfg_t    cfg_reg;
    result_t result;
    logic    byte_accept;

    assign byte_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ack_code    <= ACK_CODE_RESET;
            cfg_reg.nack_code   <= NACK_CODE_RESET;
            cfg_reg.retry_limit <= RETRY_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_ACK_CODE:    cfg_reg.ack_code    <= cfg_wdata;
                CFG_NACK_CODE:   cfg_reg.nack_code   <= cfg_wdata;
                CFG_RETRY_LIMIT: cfg_reg.retry_limit <= cfg_wdata;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    rflfr_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_tdata),
        .cfg         (cfg_reg),
        .result      (result)
    );

    rflfr_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (byte_accept),
        .result   (result),
        .ready    (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_event_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= EV_DROPPED))
        else $error("Result carries an undefined event code.");

    a_last_only_on_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tuser == EV_PAYLOAD))
        else $error("Last marker set on a report that is not payload.");

    a_reply_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == EV_ACKED || m_tuser == EV_RESEND || m_tuser == EV_DROPPED)
        |-> (m_tdata == '0))
        else $error("Reply report carries a nonzero value.");

    a_no_result_without_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !byte_accept |=> !m_tvalid)
        else $error("Result appeared without an input transfer.");

endmodule

`default_nettype wire
